[rtl/avr_isp_pkg.sv]
package avr_isp_pkg;

  localparam int unsigned CfgWidth = 16;

  typedef enum logic [3:0] {
    OP_ENTER    = 4'd0,
    OP_SIG      = 4'd1,
    OP_RDFLASH  = 4'd2,
    OP_LOADWORD = 4'd3,
    OP_COMMIT   = 4'd4,
    OP_ERASE    = 4'd5,
    OP_RDEE     = 4'd6,
    OP_WREE     = 4'd7,
    OP_WRFUSE   = 4'd8,
    OP_RDFUSE   = 4'd9,
    OP_POLL     = 4'd10,
    OP_REPLY    = 4'd11
  } opcode_t;

  typedef enum logic [0:0] {
    REG_BUSY_POLL_LIMIT = 1'b0,
    REG_ENTRY_ATTEMPTS  = 1'b1
  } cfg_reg_t;

  localparam logic [15:0] BusyPollLimitReset = 16'd4000;
  localparam logic [3:0]  EntryAttemptsReset = 4'd4;

  localparam logic [7:0] ByteProgEnable = 8'hAC;
  localparam logic [7:0] ByteEcho       = 8'h53;
  localparam logic [7:0] BytePoll       = 8'hF0;
  localparam logic [7:0] ByteRdFlashLo  = 8'h20;
  localparam logic [7:0] ByteRdFlashHi  = 8'h28;
  localparam logic [7:0] ByteLoadLo     = 8'h40;
  localparam logic [7:0] ByteLoadHi     = 8'h48;
  localparam logic [7:0] ByteCommit     = 8'h4C;
  localparam logic [7:0] ByteRdEe       = 8'hA0;
  localparam logic [7:0] ByteWrEe       = 8'hC0;
  localparam logic [7:0] ByteSig        = 8'h30;
  localparam logic [7:0] ByteErase2     = 8'h80;
  localparam logic [7:0] ByteFuseLow    = 8'hA0;
  localparam logic [7:0] ByteFuseHigh   = 8'hA8;
  localparam logic [7:0] ByteFuseExt    = 8'hA4;
  localparam logic [7:0] ByteRdFuseHi   = 8'h58;
  localparam logic [7:0] ByteRdFuseLo   = 8'h50;
  localparam logic [7:0] ByteRdFuseSel  = 8'h08;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BUSY  = 2'd1,
    PH_CMD   = 2'd2,
    PH_ENTRY = 2'd3
  } phase_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [15:0] address;
    logic [15:0] write_data;
    logic [1:0]  fuse_select;
    logic [7:0]  miso_byte;
  } isp_in_t;

  typedef struct packed {
    logic        mosi_valid;
    logic [7:0]  mosi_byte;
    logic        reset_pulse;
    logic        host_valid;
    logic [15:0] host_data;
    logic        status;
  } isp_out_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  pending_op;
    logic [1:0]  byte_index;
    logic        frame_index;
    logic [15:0] saved_address;
    logic [15:0] saved_data;
    logic [7:0]  read_word;
    logic [15:0] poll_count;
    logic [3:0]  attempt_count;
    logic        page_open;
  } isp_state_t;

  // Byte at position idx of the frame that the given state is sending.
  function automatic logic [7:0] frame_byte(isp_state_t s, logic [1:0] idx);
    logic [7:0] b0, b1, b2, b3, ah, al, lo, hi;
    logic [1:0] fs;
    logic [7:0] sel;
    ah = s.saved_address[15:8];
    al = s.saved_address[7:0];
    lo = s.saved_data[7:0];
    hi = s.saved_data[15:8];
    fs = s.saved_address[1:0];
    b0 = 8'h00;
    b1 = 8'h00;
    b2 = 8'h00;
    b3 = 8'h00;
    if (s.phase == PH_BUSY) begin
      b0 = BytePoll;
    end else if (s.phase == PH_ENTRY) begin
      b0 = ByteProgEnable;
      b1 = ByteEcho;
    end else begin
      case (s.pending_op)
        OP_SIG: begin
          b0 = ByteSig;
          b2 = al;
        end
        OP_RDFLASH: begin
          b0 = s.frame_index ? ByteRdFlashHi : ByteRdFlashLo;
          b1 = ah;
          b2 = al;
        end
        OP_LOADWORD: begin
          b0 = s.frame_index ? ByteLoadHi : ByteLoadLo;
          b1 = ah;
          b2 = al;
          b3 = s.frame_index ? hi : lo;
        end
        OP_COMMIT: begin
          b0 = ByteCommit;
          b1 = ah;
          b2 = al;
        end
        OP_ERASE: begin
          b0 = ByteProgEnable;
          b1 = ByteErase2;
        end
        OP_RDEE: begin
          b0 = ByteRdEe;
          b1 = ah;
          b2 = al;
        end
        OP_WREE: begin
          b0 = ByteWrEe;
          b1 = ah;
          b2 = al;
          b3 = lo;
        end
        OP_WRFUSE: begin
          b0 = ByteProgEnable;
          b1 = (fs == 2'd0) ? ByteFuseLow : (fs == 2'd1) ? ByteFuseHigh : ByteFuseExt;
          b3 = lo;
        end
        OP_RDFUSE: begin
          b0 = (fs == 2'd1) ? ByteRdFuseHi : ByteRdFuseLo;
          b1 = (fs == 2'd0) ? 8'h00 : ByteRdFuseSel;
        end
        default: begin
          b0 = BytePoll;
        end
      endcase
    end
    case (idx)
      2'd0:    sel = b0;
      2'd1:    sel = b1;
      2'd2:    sel = b2;
      default: sel = b3;
    endcase
    return sel;
  endfunction

endpackage

[rtl/avr_isp_command_sequencer.sv]
// AVR ISP programming master, command sequencer. The host sends one command word
// per operation on the input channel; the block answers with one output word per
// SPI byte to send (mosi_valid, with reset_pulse on the first byte of every
// programming-enable attempt), and every byte the target shifts back must be
// returned as a reply word (opcode 11) carrying miso_byte. When a command has sent
// its last frame, one output word with host_valid carries the answer: read data,
// the busy bit for a single poll, or status 1 when programming entry failed after
// entry_attempts tries. Busy polling with 0xF0 frames ends when the target reports
// ready or after busy_poll_limit polls; the command then goes on, and a fuse write
// completes. Host commands that arrive while a command is in progress, replies that
// arrive while idle, and unknown opcodes are dropped without an output word. Each
// input word is handled by a single combinational step between the state registers
// and the output register, so a new word is accepted every cycle as long as the
// output register is free or being emptied. Writing the configuration registers is
// meant for idle periods; a new value applies at once.
module avr_isp_command_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  avr_isp_pkg::isp_in_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output avr_isp_pkg::isp_out_t               out_data,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [avr_isp_pkg::CfgWidth-1:0]    cfg_data
);
  import avr_isp_pkg::*;

  isp_state_t st;
  isp_state_t st_next;
  isp_out_t   result;
  logic       fire;
  logic       accept;
  logic [15:0] busy_poll_limit;
  logic [3:0]  entry_attempts;

  // The output register is the only buffer: an item can enter whenever the
  // register is empty or its word leaves in this same cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  avr_isp_step u_step (
    .st              (st),
    .item            (in_data),
    .busy_poll_limit (busy_poll_limit),
    .entry_attempts  (entry_attempts),
    .st_next         (st_next),
    .result          (result),
    .fire            (fire)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_poll_limit <= BusyPollLimitReset;
      entry_attempts  <= EntryAttemptsReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BUSY_POLL_LIMIT: busy_poll_limit <= cfg_data;
        REG_ENTRY_ATTEMPTS:  entry_attempts  <= cfg_data[3:0];
        default:             busy_poll_limit <= busy_poll_limit;
      endcase
    end
  end

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_IDLE;
      st.pending_op    <= 4'd0;
      st.byte_index    <= 2'd0;
      st.frame_index   <= 1'b0;
      st.saved_address <= 16'd0;
      st.saved_data    <= 16'd0;
      st.read_word     <= 8'd0;
      st.poll_count    <= 16'd0;
      st.attempt_count <= 4'd0;
      st.page_open     <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (accept && fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fire) begin
      out_data <= result;
    end
  end

endmodule

[rtl/avr_isp_step.sv]
module avr_isp_step (
  input  avr_isp_pkg::isp_state_t st,
  input  avr_isp_pkg::isp_in_t    item,
  input  logic [15:0]             busy_poll_limit,
  input  logic [3:0]              entry_attempts,
  output avr_isp_pkg::isp_state_t st_next,
  output avr_isp_pkg::isp_out_t   result,
  output logic                    fire
);
  import avr_isp_pkg::*;

  logic [15:0] poll_lim;
  logic [3:0]  entry_lim;
  logic [15:0] poll_inc;
  logic [3:0]  attempt_inc;
  logic        send;
  logic        pulse;
  logic        done;
  logic [15:0] done_data;
  logic        done_status;
  logic        wait_busy;

  assign poll_lim    = (busy_poll_limit == 16'd0) ? 16'd1 : busy_poll_limit;
  assign entry_lim   = (entry_attempts == 4'd0) ? 4'd1 : entry_attempts;
  assign poll_inc    = (st.poll_count != 16'hFFFF) ? st.poll_count + 16'd1 : st.poll_count;
  assign attempt_inc = (st.attempt_count != 4'hF) ? st.attempt_count + 4'd1 : st.attempt_count;

  always_comb begin
    st_next     = st;
    fire        = 1'b0;
    send        = 1'b0;
    pulse       = 1'b0;
    done        = 1'b0;
    done_data   = 16'd0;
    done_status = 1'b0;
    wait_busy   = 1'b0;

    if (st.phase == PH_IDLE) begin
      if (item.opcode <= OP_POLL) begin
        fire                 = 1'b1;
        send                 = 1'b1;
        st_next.pending_op   = item.opcode;
        st_next.frame_index  = 1'b0;
        st_next.read_word    = 8'd0;
        st_next.poll_count   = 16'd0;
        st_next.byte_index   = 2'd0;
        st_next.saved_data   = item.write_data;
        if (item.opcode == OP_WRFUSE || item.opcode == OP_RDFUSE) begin
          st_next.saved_address = {14'd0, item.fuse_select};
        end else begin
          st_next.saved_address = item.address;
        end
        if (item.opcode == OP_ENTER) begin
          st_next.attempt_count = 4'd0;
          st_next.page_open     = 1'b0;
          st_next.phase         = PH_ENTRY;
          pulse                 = 1'b1;
        end else begin
          wait_busy = (item.opcode == OP_SIG) || (item.opcode == OP_ERASE) ||
                      (item.opcode == OP_WREE) ||
                      ((item.opcode == OP_LOADWORD || item.opcode == OP_COMMIT) &&
                       !st.page_open);
          if (item.opcode == OP_LOADWORD) begin
            st_next.page_open = 1'b1;
          end
          st_next.phase = wait_busy ? PH_BUSY : PH_CMD;
        end
      end
    end else if (item.opcode == OP_REPLY) begin
      fire = 1'b1;
      if (st.byte_index != 2'd3) begin
        if (st.phase == PH_ENTRY && st.byte_index == 2'd2) begin
          st_next.read_word = item.miso_byte;
        end
        st_next.byte_index = st.byte_index + 2'd1;
        send               = 1'b1;
      end else begin
        st_next.byte_index = 2'd0;
        case (st.phase)
          PH_BUSY: begin
            st_next.poll_count = poll_inc;
            if (item.miso_byte[0] && poll_inc < poll_lim) begin
              send = 1'b1;
            end else if (st.pending_op == OP_WRFUSE) begin
              done = 1'b1;
            end else begin
              st_next.frame_index = 1'b0;
              st_next.phase       = PH_CMD;
              send                = 1'b1;
            end
          end
          PH_ENTRY: begin
            if (st.read_word == ByteEcho) begin
              done = 1'b1;
            end else begin
              st_next.attempt_count = attempt_inc;
              if (attempt_inc >= entry_lim) begin
                done        = 1'b1;
                done_status = 1'b1;
              end else begin
                st_next.read_word = 8'd0;
                send              = 1'b1;
                pulse             = 1'b1;
              end
            end
          end
          default: begin
            case (st.pending_op)
              OP_RDFLASH: begin
                if (!st.frame_index) begin
                  st_next.read_word   = item.miso_byte;
                  st_next.frame_index = 1'b1;
                  send                = 1'b1;
                end else begin
                  done      = 1'b1;
                  done_data = {item.miso_byte, st.read_word};
                end
              end
              OP_LOADWORD: begin
                if (!st.frame_index) begin
                  st_next.frame_index = 1'b1;
                  send                = 1'b1;
                end else begin
                  done = 1'b1;
                end
              end
              OP_COMMIT: begin
                st_next.page_open = 1'b0;
                done              = 1'b1;
              end
              OP_WRFUSE: begin
                st_next.poll_count = 16'd0;
                st_next.phase      = PH_BUSY;
                send               = 1'b1;
              end
              OP_SIG, OP_RDEE, OP_RDFUSE: begin
                done      = 1'b1;
                done_data = {8'd0, item.miso_byte};
              end
              OP_POLL: begin
                done      = 1'b1;
                done_data = {15'd0, item.miso_byte[0]};
              end
              default: begin
                done = 1'b1;
              end
            endcase
          end
        endcase
      end
    end

    if (done) begin
      st_next.phase       = PH_IDLE;
      st_next.byte_index  = 2'd0;
      st_next.frame_index = 1'b0;
    end

    result.mosi_valid  = send;
    result.mosi_byte   = send ? frame_byte(st_next, st_next.byte_index) : 8'd0;
    result.reset_pulse = pulse;
    result.host_valid  = done;
    result.host_data   = done_data;
    result.status      = done_status;
  end

endmodule

[rtl/avr_isp_checker.sv]
module avr_isp_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input avr_isp_pkg::isp_out_t out_data
);
  import avr_isp_pkg::*;

  // A word the sink holds off stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // A word either drives the SPI side or completes a host command, never both.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.mosi_valid && out_data.host_valid))
    else $error("output word is both SPI byte and host answer");

  // Without an SPI byte there is no byte value and no reset pulse.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.mosi_valid |-> out_data.mosi_byte == 8'd0 &&
                                          !out_data.reset_pulse)
    else $error("idle SPI fields not cleared");

  // Host answer fields are zero unless a command completes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.host_valid |-> out_data.host_data == 16'd0 &&
                                          !out_data.status)
    else $error("host fields set without completion");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind avr_isp_command_sequencer avr_isp_checker u_avr_isp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
